[hdl/pwq_pkg.sv]
// Package for the pulse width qualifier.
// Holds the result kind codes and the register index codes; no dependencies.
package pwq_pkg;

   typedef enum logic [2:0] {
      KIND_LEAD   = 3'd0,
      KIND_STRAY  = 3'd1,
      KIND_REJECT = 3'd2,
      KIND_ACCEPT = 3'd3,
      KIND_CLEAR  = 3'd4
   } kind_type;

   typedef enum logic [1:0] {
      CSR_POLARITY  = 2'd0,
      CSR_MIN_WIDTH = 2'd1,
      CSR_MAX_WIDTH = 2'd2,
      CSR_UNUSED    = 2'd3
   } csr_index_type;

   localparam logic [31:0] MIN_WIDTH_RESET = 32'd10;
   localparam logic [31:0] MAX_WIDTH_RESET = 32'd1000;

endpackage

[hdl/pulse_width_qualifier.sv]
// An input register and then a response register part the two sides; the latter drives
// rsp_valid. Throughput: one transaction per cycle while rsp_ready does not stall it;
// capture state updates as an item leaves the input register.
// Reset (synchronous, active high) empties both registers, zeroes the capture state
// and restores high-level polarity, min_width_ms = 10, max_width_ms = 1000.
// Uses pwq_pkg.
module pulse_width_qualifier
   import pwq_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_action,
   input  logic        req_pin_level,
   input  logic [31:0] req_time_ms,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_event_kind,
   output logic [31:0] rsp_pulse_count,
   output logic [31:0] rsp_reject_count,
   output logic [31:0] rsp_last_start_ms,
   output logic [31:0] rsp_last_period_ms,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   logic        polarity_ff;
   logic [31:0] min_width_ff;
   logic [31:0] max_width_ff;

   logic        in_valid_ff;
   logic        in_action_ff;
   logic        in_level_ff;
   logic [31:0] in_time_ff;

   logic [31:0] edge_start_ff, edge_start_in;
   logic        edge_armed_ff, edge_armed_in;
   logic [31:0] prev_start_ff, prev_start_in;
   logic [31:0] period_ff, period_in;
   logic [31:0] accepted_ff, accepted_in;
   logic [31:0] rejected_ff, rejected_in;
   kind_type    kind_in;

   logic        out_valid_ff;
   logic [2:0]  out_kind_ff;
   logic [31:0] out_pulse_ff;
   logic [31:0] out_reject_ff;
   logic [31:0] out_start_ff;
   logic [31:0] out_period_ff;

   logic        out_free;
   logic        advance;
   logic [31:0] width;

   assign out_free  = !out_valid_ff || rsp_ready;
   assign advance   = in_valid_ff && out_free;
   assign req_ready = !in_valid_ff || out_free;
   assign csr_ready = 1'b1;
   assign width     = in_time_ff - edge_start_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         polarity_ff  <= 1'b1;
         min_width_ff <= MIN_WIDTH_RESET;
         max_width_ff <= MAX_WIDTH_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index_type'(csr_index))
            CSR_POLARITY:  polarity_ff  <= csr_wdata[0];
            CSR_MIN_WIDTH: min_width_ff <= csr_wdata;
            CSR_MAX_WIDTH: max_width_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_action_ff <= req_action;
         in_level_ff  <= req_pin_level;
         in_time_ff   <= req_time_ms;
      end
   end

   always_comb begin
      edge_start_in = edge_start_ff;
      edge_armed_in = edge_armed_ff;
      prev_start_in = prev_start_ff;
      period_in     = period_ff;
      accepted_in   = accepted_ff;
      rejected_in   = rejected_ff;
      if (in_action_ff) begin
         edge_start_in = '0;
         edge_armed_in = 1'b0;
         prev_start_in = '0;
         period_in     = '0;
         accepted_in   = '0;
         rejected_in   = '0;
         kind_in       = KIND_CLEAR;
      end else if (in_level_ff == polarity_ff) begin
         edge_start_in = in_time_ff;
         edge_armed_in = 1'b1;
         kind_in       = KIND_LEAD;
      end else if (!edge_armed_ff) begin
         kind_in = KIND_STRAY;
      end else begin
         edge_armed_in = 1'b0;
         if (width < min_width_ff || width > max_width_ff) begin
            rejected_in = rejected_ff + 32'd1;
            kind_in     = KIND_REJECT;
         end else begin
            if (accepted_ff != '0) begin
               period_in = edge_start_ff - prev_start_ff;
            end
            prev_start_in = edge_start_ff;
            accepted_in   = accepted_ff + 32'd1;
            kind_in       = KIND_ACCEPT;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         edge_start_ff <= '0;
         edge_armed_ff <= 1'b0;
         prev_start_ff <= '0;
         period_ff     <= '0;
         accepted_ff   <= '0;
         rejected_ff   <= '0;
      end else if (advance) begin
         edge_start_ff <= edge_start_in;
         edge_armed_ff <= edge_armed_in;
         prev_start_ff <= prev_start_in;
         period_ff     <= period_in;
         accepted_ff   <= accepted_in;
         rejected_ff   <= rejected_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_free) begin
         out_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_kind_ff   <= kind_in;
         out_pulse_ff  <= accepted_in;
         out_reject_ff <= rejected_in;
         out_start_ff  <= prev_start_in;
         out_period_ff <= period_in;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_event_kind     = out_kind_ff;
   assign rsp_pulse_count    = out_pulse_ff;
   assign rsp_reject_count   = out_reject_ff;
   assign rsp_last_start_ms  = out_start_ff;
   assign rsp_last_period_ms = out_period_ff;

endmodule

[hdl/pwq_checker.sv]
// Port-level checks for the pulse width qualifier, bound to the top level.
// Uses pwq_pkg.
module pwq_assert
   import pwq_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [2:0]  rsp_event_kind,
   input logic [31:0] rsp_pulse_count,
   input logic [31:0] rsp_reject_count,
   input logic [31:0] rsp_last_start_ms,
   input logic [31:0] rsp_last_period_ms
);

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_event_kind)
         && $stable(rsp_pulse_count) && $stable(rsp_reject_count))
      else $error("stalled response transaction changed");

   a_kind_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_event_kind == KIND_LEAD || rsp_event_kind == KIND_STRAY
         || rsp_event_kind == KIND_REJECT || rsp_event_kind == KIND_ACCEPT
         || rsp_event_kind == KIND_CLEAR)
      else $error("undefined event kind");

   a_clear_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_event_kind == KIND_CLEAR |-> rsp_pulse_count == '0
         && rsp_reject_count == '0 && rsp_last_start_ms == '0
         && rsp_last_period_ms == '0)
      else $error("clear response carries stale capture state");

endmodule

bind pulse_width_qualifier pwq_assert u_pwq_assert (.*);
